[hdl/sec_pkg.sv]
package sec_pkg;

    localparam int CW = 48;
    localparam int ZW = 20;
    localparam int ITER = 16;
    localparam int ITER_W = $clog2(ITER);
    localparam int DIV_CNT_W = $clog2(CW);

    localparam int HALF_PI_Q16 = 102944;
    localparam int PI_Q16 = 205887;

    localparam logic signed [CW-1:0] COR_ONE = CW'(64'sd1 <<< 30);

    localparam logic [1:0] ST_NONE  = 2'd0;
    localparam logic [1:0] ST_FRONT = 2'd1;
    localparam logic [1:0] ST_REAR  = 2'd2;
    localparam logic [1:0] ST_OFF   = 2'd3;

    localparam logic [2:0] REG_FRONT_STIFF = 3'd0;
    localparam logic [2:0] REG_REAR_STIFF  = 3'd1;
    localparam logic [2:0] REG_FRONT_SHORE = 3'd2;
    localparam logic [2:0] REG_REAR_SHORE  = 3'd3;
    localparam logic [2:0] REG_FRONT_SAFE  = 3'd4;
    localparam logic [2:0] REG_REAR_SAFE   = 3'd5;
    localparam logic [2:0] REG_FRONT_GAIN  = 3'd6;
    localparam logic [2:0] REG_REAR_GAIN   = 3'd7;

    typedef struct packed {
        logic start;
        logic vectoring;
    } cor_cmd_t;

    typedef struct packed {
        logic busy;
        logic done;
    } unit_stat_t;

    function automatic logic signed [ZW-1:0] atan_entry(input logic [ITER_W-1:0] i);
        logic signed [ZW-1:0] v;
        case (i)
            4'd0:    v = 20'sd51472;
            4'd1:    v = 20'sd30385;
            4'd2:    v = 20'sd16055;
            4'd3:    v = 20'sd8150;
            4'd4:    v = 20'sd4091;
            4'd5:    v = 20'sd2047;
            4'd6:    v = 20'sd1024;
            4'd7:    v = 20'sd512;
            4'd8:    v = 20'sd256;
            4'd9:    v = 20'sd128;
            4'd10:   v = 20'sd64;
            4'd11:   v = 20'sd32;
            4'd12:   v = 20'sd16;
            4'd13:   v = 20'sd8;
            4'd14:   v = 20'sd4;
            4'd15:   v = 20'sd2;
            default: v = 20'sd0;
        endcase
        return v;
    endfunction

endpackage

[hdl/sec_cordic.sv]
module sec_cordic
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  sec_pkg::cor_cmd_t                cmd,
    input  logic signed [sec_pkg::CW-1:0]    x_in,
    input  logic signed [sec_pkg::CW-1:0]    y_in,
    input  logic signed [sec_pkg::ZW-1:0]    z_in,
    output sec_pkg::unit_stat_t              stat,
    output logic signed [sec_pkg::CW-1:0]    x_out,
    output logic signed [sec_pkg::CW-1:0]    y_out,
    output logic signed [sec_pkg::ZW-1:0]    z_out
);

    logic signed [sec_pkg::CW-1:0]     x_reg;
    logic signed [sec_pkg::CW-1:0]     y_reg;
    logic signed [sec_pkg::ZW-1:0]     z_reg;
    logic [sec_pkg::ITER_W-1:0]        iter_reg;
    logic                              vec_reg;
    logic                              busy_reg;
    logic                              done_reg;
    logic signed [sec_pkg::CW-1:0]     dx;
    logic signed [sec_pkg::CW-1:0]     dy;
    logic signed [sec_pkg::ZW-1:0]     ang;
    logic                              pos;
    logic                              up;

    always_comb
    begin
        dx  = y_reg >>> iter_reg;
        dy  = x_reg >>> iter_reg;
        ang = sec_pkg::atan_entry(iter_reg);
        pos = vec_reg ? (y_reg > 0) : (z_reg >= 0);
        up  = vec_reg ? pos : !pos;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            iter_reg <= '0;
            vec_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (cmd.start)
            begin
                busy_reg <= 1'b1;
                iter_reg <= '0;
                vec_reg  <= cmd.vectoring;
            end
            else if (busy_reg)
            begin
                if (iter_reg == sec_pkg::ITER_W'(sec_pkg::ITER - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    iter_reg <= iter_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            x_reg <= x_in;
            y_reg <= y_in;
            z_reg <= z_in;
        end
        else if (busy_reg)
        begin
            if (up)
            begin
                x_reg <= x_reg + dx;
                y_reg <= y_reg - dy;
                z_reg <= z_reg + ang;
            end
            else
            begin
                x_reg <= x_reg - dx;
                y_reg <= y_reg + dy;
                z_reg <= z_reg - ang;
            end
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign x_out = x_reg;
    assign y_out = y_reg;
    assign z_out = z_reg;

endmodule

[hdl/sec_div.sv]
module sec_div
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    input  logic signed [sec_pkg::CW-1:0]    dividend,
    input  logic signed [sec_pkg::CW-1:0]    divisor,
    output sec_pkg::unit_stat_t              stat,
    output logic signed [sec_pkg::CW-1:0]    quotient
);

    logic [sec_pkg::CW-1:0]            q_reg;
    logic [sec_pkg::CW-1:0]            rem_reg;
    logic [sec_pkg::CW-1:0]            den_reg;
    logic                              neg_reg;
    logic [sec_pkg::DIV_CNT_W-1:0]     cnt_reg;
    logic                              busy_reg;
    logic                              done_reg;
    logic [sec_pkg::CW:0]              rem_shift;
    logic                              fits;

    always_comb
    begin
        rem_shift = {rem_reg, q_reg[sec_pkg::CW-1]};
        fits      = rem_shift >= {1'b0, den_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                if (cnt_reg == sec_pkg::DIV_CNT_W'(sec_pkg::CW - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_reg   <= dividend[sec_pkg::CW-1] ? 48'(-dividend) : 48'(dividend);
            den_reg <= divisor[sec_pkg::CW-1] ? 48'(-divisor) : 48'(divisor);
            rem_reg <= '0;
            neg_reg <= dividend[sec_pkg::CW-1] ^ divisor[sec_pkg::CW-1];
        end
        else if (busy_reg)
        begin
            if (fits)
            begin
                rem_reg <= sec_pkg::CW'(rem_shift - {1'b0, den_reg});
                q_reg   <= {q_reg[sec_pkg::CW-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= sec_pkg::CW'(rem_shift);
                q_reg   <= {q_reg[sec_pkg::CW-2:0], 1'b0};
            end
        end
    end

    assign quotient  = neg_reg ? -$signed(q_reg) : $signed(q_reg);
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

[hdl/slip_envelope_steer_controller_unit.sv]
// Slip-envelope steering controller.
// Input channel (in_valid/in_ready) carries one vehicle sample per transfer;
// output channel (out_valid/out_ready) returns steer_addition and status.
// Eight configuration registers sit on the APB-style port at 4*index; they
// are to be written only while the block is idle, which the block itself
// does not enforce. pready is always high. An enabled sample above the
// speed floor runs up to five 48-step divisions on the shared restoring
// divider, three 16-step runs of the shared CORDIC unit, up to five
// angle-reduction steps and its sequencer states before its result loads
// the output register; the sequencer then returns to idle before the next
// transfer. A disabled or slow sample goes straight to the output state.
// One sample is worked on at a time; in_ready is high only while the
// sequencer is idle, and the next sample is taken while a result still
// waits in the output register.
// If the receiver stalls, the result holds in the output register and a
// finished next result waits in the sequencer until the register frees.
// Reset restores the register defaults, clears the kept steer and yaw rate
// and drops any pending result.
module slip_envelope_steer_controller_unit
#(
    parameter int FRONT_AXLE_MM = 1350,
    parameter int REAR_AXLE_MM  = 1450,
    parameter int MASS_KG       = 1700,
    parameter int SPEED_FLOOR   = 256
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [4:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [15:0]        friction_est,
    input  logic signed [15:0] front_slip_est,
    input  logic signed [15:0] driver_steer,
    input  logic signed [15:0] yaw_rate,
    input  logic [15:0]        speed,
    input  logic               at_shoreline,
    input  logic signed [15:0] measured_steer,
    input  logic               enable,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [15:0] steer_addition,
    output logic [1:0]         status
);

    localparam longint WEIGHT_CN = longint'(MASS_KG) * 981;
    localparam longint FNF_CN = (WEIGHT_CN * REAR_AXLE_MM) / (FRONT_AXLE_MM + REAR_AXLE_MM);
    localparam longint FNR_CN = WEIGHT_CN - FNF_CN;
    localparam longint FN3_F = 3 * FNF_CN;
    localparam longint FN3_R = 3 * FNR_CN;
    localparam longint K_FRONT = longint'(FRONT_AXLE_MM) * 256;
    localparam longint K_BOTH = longint'(FRONT_AXLE_MM + REAR_AXLE_MM) * 256;

    localparam logic [4:0] S_IDLE  = 5'd0;
    localparam logic [4:0] S_RED   = 5'd1;
    localparam logic [4:0] S_TAN_W = 5'd2;
    localparam logic [4:0] S_TAN_S = 5'd3;
    localparam logic [4:0] S_TAN_D = 5'd4;
    localparam logic [4:0] S_R1_S  = 5'd5;
    localparam logic [4:0] S_R1_W  = 5'd6;
    localparam logic [4:0] S_R2_S  = 5'd7;
    localparam logic [4:0] S_R2_W  = 5'd8;
    localparam logic [4:0] S_R3_S  = 5'd9;
    localparam logic [4:0] S_R3_W  = 5'd10;
    localparam logic [4:0] S_TH_C  = 5'd11;
    localparam logic [4:0] S_TH_V  = 5'd12;
    localparam logic [4:0] S_TH_W  = 5'd13;
    localparam logic [4:0] S_TH_M  = 5'd14;
    localparam logic [4:0] S_CALC  = 5'd15;
    localparam logic [4:0] S_DEC   = 5'd16;
    localparam logic [4:0] S_DS_S  = 5'd17;
    localparam logic [4:0] S_DS_W  = 5'd18;
    localparam logic [4:0] S_GAIN  = 5'd19;
    localparam logic [4:0] S_FIN   = 5'd20;
    localparam logic [4:0] S_OUT   = 5'd21;

    logic [19:0]        front_stiff_reg;
    logic [19:0]        rear_stiff_reg;
    logic [15:0]        front_shore_reg;
    logic [15:0]        rear_shore_reg;
    logic [15:0]        front_safe_reg;
    logic [15:0]        rear_safe_reg;
    logic [15:0]        front_gain_reg;
    logic [15:0]        rear_gain_reg;

    logic signed [15:0] last_steer_reg;
    logic signed [15:0] last_yaw_reg;

    logic [4:0]         state_reg;
    logic [4:0]         state_next;

    logic [15:0]        mu_reg;
    logic signed [15:0] af_reg;
    logic signed [15:0] dhw_reg;
    logic signed [15:0] r_reg;
    logic [15:0]        v_reg;
    logic               shore_reg;
    logic signed [15:0] ls_reg;
    logic signed [15:0] ly_reg;
    logic signed [16:0] th_reg;
    logic signed [21:0] z_red_reg;
    logic               tan_pos_reg;
    logic signed [15:0] tan_reg;
    logic signed [31:0] r1_reg;
    logic signed [31:0] r2_reg;
    logic signed [31:0] r3_reg;
    logic               axle_reg;
    logic [21:0]        c_reg;
    logic [16:0]        ang_reg;
    logic [13:0]        tf_reg;
    logic [13:0]        tr_reg;
    logic signed [31:0] ar_reg;
    logic signed [31:0] afhw_reg;
    logic               rear_reg;
    logic signed [31:0] a_reg;
    logic [13:0]        t_reg;
    logic signed [31:0] des_reg;
    logic signed [50:0] prod_reg;
    logic signed [15:0] res_add_reg;
    logic [1:0]         res_status_reg;
    logic               out_valid_reg;
    logic signed [15:0] out_add_reg;
    logic [1:0]         out_status_reg;

    logic               cfg_write;
    logic               in_xfer;
    logic               run_ok;
    logic signed [16:0] th_in;
    logic               out_load;

    sec_pkg::cor_cmd_t              cor_cmd;
    sec_pkg::unit_stat_t            cor_stat;
    logic signed [sec_pkg::CW-1:0]  cor_x_in;
    logic signed [sec_pkg::CW-1:0]  cor_y_in;
    logic signed [sec_pkg::ZW-1:0]  cor_z_in;
    logic signed [sec_pkg::CW-1:0]  cor_x;
    logic signed [sec_pkg::CW-1:0]  cor_y;
    logic signed [sec_pkg::ZW-1:0]  cor_z;

    logic                           div_start;
    sec_pkg::unit_stat_t            div_stat;
    logic signed [sec_pkg::CW-1:0]  div_a;
    logic signed [sec_pkg::CW-1:0]  div_b;
    logic signed [sec_pkg::CW-1:0]  div_q;

    logic signed [33:0] a_ext;
    logic signed [33:0] a_abs;
    logic signed [33:0] d_raw;
    logic signed [33:0] d_val;
    logic signed [32:0] ar_abs;
    logic signed [32:0] afhw_abs;
    logic signed [33:0] diff;
    logic [32:0]        safe_prod;
    logic signed [39:0] fin_sum;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign in_ready  = (state_reg == S_IDLE);
    assign in_xfer   = in_valid && in_ready;
    assign run_ok    = enable && (32'(speed) > 32'(SPEED_FLOOR));
    assign th_in     = 17'(front_slip_est) + 17'(last_steer_reg);
    assign out_load  = (state_reg == S_OUT) && (!out_valid_reg || out_ready);

    always_comb
    begin
        case (paddr[4:2])
            sec_pkg::REG_FRONT_STIFF: prdata = 32'(front_stiff_reg);
            sec_pkg::REG_REAR_STIFF:  prdata = 32'(rear_stiff_reg);
            sec_pkg::REG_FRONT_SHORE: prdata = 32'(front_shore_reg);
            sec_pkg::REG_REAR_SHORE:  prdata = 32'(rear_shore_reg);
            sec_pkg::REG_FRONT_SAFE:  prdata = 32'(front_safe_reg);
            sec_pkg::REG_REAR_SAFE:   prdata = 32'(rear_safe_reg);
            sec_pkg::REG_FRONT_GAIN:  prdata = 32'(front_gain_reg);
            sec_pkg::REG_REAR_GAIN:   prdata = 32'(rear_gain_reg);
            default:                  prdata = 32'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_stiff_reg <= 20'd100000;
            rear_stiff_reg  <= 20'd150000;
            front_shore_reg <= 16'd16384;
            rear_shore_reg  <= 16'd16384;
            front_safe_reg  <= 16'd32768;
            rear_safe_reg   <= 16'd32768;
            front_gain_reg  <= 16'd4096;
            rear_gain_reg   <= 16'd4096;
        end
        else if (cfg_write)
        begin
            case (paddr[4:2])
                sec_pkg::REG_FRONT_STIFF: front_stiff_reg <= pwdata[19:0];
                sec_pkg::REG_REAR_STIFF:  rear_stiff_reg  <= pwdata[19:0];
                sec_pkg::REG_FRONT_SHORE: front_shore_reg <= pwdata[15:0];
                sec_pkg::REG_REAR_SHORE:  rear_shore_reg  <= pwdata[15:0];
                sec_pkg::REG_FRONT_SAFE:  front_safe_reg  <= pwdata[15:0];
                sec_pkg::REG_REAR_SAFE:   rear_safe_reg   <= pwdata[15:0];
                sec_pkg::REG_FRONT_GAIN:  front_gain_reg  <= pwdata[15:0];
                sec_pkg::REG_REAR_GAIN:   rear_gain_reg   <= pwdata[15:0];
                default:                  front_gain_reg  <= front_gain_reg;
            endcase
        end
    end

    always_comb
    begin
        a_ext    = 34'(a_reg);
        a_abs    = (a_ext < 0) ? -a_ext : a_ext;
        d_raw    = 34'sd12288 - a_abs + $signed({20'd0, t_reg});
        d_val    = (d_raw == 34'sd0) ? 34'sd1 : d_raw;
        ar_abs   = (ar_reg < 0) ? -33'(ar_reg) : 33'(ar_reg);
        afhw_abs = (afhw_reg < 0) ? -33'(afhw_reg) : 33'(afhw_reg);
        diff     = (rear_reg ? 34'(ar_reg) : 34'(af_reg)) - 34'(des_reg);
        safe_prod = (axle_reg ? rear_safe_reg : front_safe_reg) * ang_reg;
        fin_sum  = (rear_reg ? 40'sd0 : 40'(ls_reg)) + 40'(prod_reg >>> 12) - 40'(dhw_reg);
    end

    always_comb
    begin
        cor_cmd.start     = 1'b0;
        cor_cmd.vectoring = 1'b0;
        cor_x_in          = sec_pkg::COR_ONE;
        cor_y_in          = '0;
        cor_z_in          = sec_pkg::ZW'(z_red_reg);
        if (state_reg == S_RED && z_red_reg <= sec_pkg::HALF_PI_Q16
            && z_red_reg >= -sec_pkg::HALF_PI_Q16)
        begin
            cor_cmd.start = 1'b1;
        end
        else if (state_reg == S_TH_V)
        begin
            cor_cmd.start     = 1'b1;
            cor_cmd.vectoring = 1'b1;
            cor_x_in = sec_pkg::CW'(longint'(c_reg) * 64'sd1638400);
            cor_y_in = sec_pkg::CW'(longint'(mu_reg) * (axle_reg ? FN3_R : FN3_F));
            cor_z_in = '0;
        end
    end

    always_comb
    begin
        div_start = 1'b0;
        div_a     = '0;
        div_b     = sec_pkg::CW'(longint'(v_reg) * 64'sd1000);
        case (state_reg)
            S_TAN_S:
            begin
                div_start = 1'b1;
                div_a     = cor_y <<< 12;
                div_b     = cor_x;
            end
            S_R1_S:
            begin
                div_start = 1'b1;
                div_a     = sec_pkg::CW'(longint'(ly_reg) * K_FRONT);
            end
            S_R2_S:
            begin
                div_start = 1'b1;
                div_a     = sec_pkg::CW'(longint'(ly_reg) * K_BOTH);
            end
            S_R3_S:
            begin
                div_start = 1'b1;
                div_a     = sec_pkg::CW'(longint'(r_reg) * K_FRONT);
            end
            S_DS_S:
            begin
                div_start = 1'b1;
                if (a_reg > 0)
                    div_a = sec_pkg::CW'(longint'(t_reg) * 64'sd12288);
                else if (a_reg < 0)
                    div_a = -sec_pkg::CW'(longint'(t_reg) * 64'sd12288);
                else
                    div_a = '0;
                div_b     = sec_pkg::CW'(d_val);
            end
            default:
            begin
                div_start = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:  if (in_xfer) state_next = run_ok ? S_RED : S_OUT;
            S_RED:   if (cor_cmd.start) state_next = S_TAN_W;
            S_TAN_W: if (cor_stat.done) state_next = (cor_x <= 0) ? S_R1_S : S_TAN_S;
            S_TAN_S: state_next = S_TAN_D;
            S_TAN_D: if (div_stat.done) state_next = S_R1_S;
            S_R1_S:  state_next = S_R1_W;
            S_R1_W:  if (div_stat.done) state_next = S_R2_S;
            S_R2_S:  state_next = S_R2_W;
            S_R2_W:  if (div_stat.done) state_next = S_R3_S;
            S_R3_S:  state_next = S_R3_W;
            S_R3_W:  if (div_stat.done) state_next = S_TH_C;
            S_TH_C:  state_next = S_TH_V;
            S_TH_V:  state_next = S_TH_W;
            S_TH_W:  if (cor_stat.done) state_next = S_TH_M;
            S_TH_M:  state_next = axle_reg ? S_CALC : S_TH_C;
            S_CALC:  state_next = S_DEC;
            S_DEC:
            begin
                if (ar_abs > 33'(tr_reg) || afhw_abs >= 33'(tf_reg))
                    state_next = S_DS_S;
                else
                    state_next = S_OUT;
            end
            S_DS_S:  state_next = S_DS_W;
            S_DS_W:  if (div_stat.done) state_next = S_GAIN;
            S_GAIN:  state_next = S_FIN;
            S_FIN:   state_next = S_OUT;
            S_OUT:   if (out_load) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            last_steer_reg <= 16'sd0;
            last_yaw_reg   <= 16'sd0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (in_xfer)
            begin
                last_steer_reg <= measured_steer;
                last_yaw_reg   <= yaw_rate;
            end
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_add_reg    <= res_add_reg;
            out_status_reg <= res_status_reg;
        end
        case (state_reg)
            S_IDLE:
            begin
                mu_reg      <= friction_est;
                af_reg      <= front_slip_est;
                dhw_reg     <= driver_steer;
                r_reg       <= yaw_rate;
                v_reg       <= speed;
                shore_reg   <= at_shoreline;
                ls_reg      <= last_steer_reg;
                ly_reg      <= last_yaw_reg;
                th_reg      <= th_in;
                z_red_reg   <= 22'(th_in) <<< 4;
                axle_reg    <= 1'b0;
                res_add_reg <= 16'sd0;
                res_status_reg <= sec_pkg::ST_OFF;
            end
            S_RED:
            begin
                tan_pos_reg <= !z_red_reg[21];
                if (z_red_reg > sec_pkg::HALF_PI_Q16)
                    z_red_reg <= z_red_reg - 22'(sec_pkg::PI_Q16);
                else if (z_red_reg < -sec_pkg::HALF_PI_Q16)
                    z_red_reg <= z_red_reg + 22'(sec_pkg::PI_Q16);
            end
            S_TAN_W:
            begin
                if (cor_stat.done && cor_x <= 0)
                    tan_reg <= tan_pos_reg ? 16'sd32767 : -16'sd32767;
            end
            S_TAN_D:
            begin
                if (div_q > 32767)
                    tan_reg <= 16'sd32767;
                else if (div_q < -32767)
                    tan_reg <= -16'sd32767;
                else
                    tan_reg <= 16'(div_q);
            end
            S_R1_W: if (div_stat.done) r1_reg <= 32'(div_q);
            S_R2_W: if (div_stat.done) r2_reg <= 32'(div_q);
            S_R3_W: if (div_stat.done) r3_reg <= 32'(div_q);
            S_TH_C:
            begin
                if (axle_reg)
                    c_reg <= shore_reg ? 22'((36'(rear_stiff_reg) * rear_shore_reg) >> 14)
                                       : 22'(rear_stiff_reg);
                else
                    c_reg <= shore_reg ? 22'((36'(front_stiff_reg) * front_shore_reg) >> 14)
                                       : 22'(front_stiff_reg);
            end
            S_TH_W:
            begin
                if (cor_z < 0)
                    ang_reg <= 17'd0;
                else if (cor_z > sec_pkg::HALF_PI_Q16)
                    ang_reg <= 17'(sec_pkg::HALF_PI_Q16);
                else
                    ang_reg <= 17'(cor_z);
            end
            S_TH_M:
            begin
                if (axle_reg)
                    tr_reg <= 14'((34'(safe_prod) + 34'd262144) >> 19);
                else
                    tf_reg <= 14'((34'(safe_prod) + 34'd262144) >> 19);
                axle_reg <= 1'b1;
            end
            S_CALC:
            begin
                ar_reg   <= 32'(th_reg) - r2_reg;
                afhw_reg <= 32'(tan_reg) - r1_reg + r3_reg - 32'(dhw_reg);
            end
            S_DEC:
            begin
                if (ar_abs > 33'(tr_reg))
                begin
                    rear_reg       <= 1'b1;
                    a_reg          <= ar_reg;
                    t_reg          <= tr_reg;
                    res_status_reg <= sec_pkg::ST_REAR;
                end
                else if (afhw_abs < 33'(tf_reg))
                begin
                    rear_reg       <= 1'b0;
                    res_add_reg    <= 16'sd0;
                    res_status_reg <= sec_pkg::ST_NONE;
                end
                else
                begin
                    rear_reg       <= 1'b0;
                    a_reg          <= afhw_reg;
                    t_reg          <= tf_reg;
                    res_status_reg <= sec_pkg::ST_FRONT;
                end
            end
            S_DS_W: if (div_stat.done) des_reg <= 32'(div_q);
            S_GAIN:
            begin
                prod_reg <= $signed({1'b0, (rear_reg ? rear_gain_reg : front_gain_reg)})
                            * 51'(diff);
            end
            S_FIN:
            begin
                if (fin_sum > 40'sd32767)
                    res_add_reg <= 16'sd32767;
                else if (fin_sum < -40'sd32768)
                    res_add_reg <= -16'sd32768;
                else
                    res_add_reg <= 16'(fin_sum);
            end
            default:
            begin
                des_reg <= des_reg;
            end
        endcase
    end

    sec_cordic u_cordic
    (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cor_cmd),
        .x_in  (cor_x_in),
        .y_in  (cor_y_in),
        .z_in  (cor_z_in),
        .stat  (cor_stat),
        .x_out (cor_x),
        .y_out (cor_y),
        .z_out (cor_z)
    );

    sec_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_a),
        .divisor  (div_b),
        .stat     (div_stat),
        .quotient (div_q)
    );

    assign out_valid      = out_valid_reg;
    assign steer_addition = out_add_reg;
    assign status         = out_status_reg;

    a_idle_units: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> (!cor_stat.busy && !div_stat.busy))
        else $error("shared unit busy while sequencer idle");

    a_off_path: assert property (@(posedge clk) disable iff (!rst_n)
        (in_xfer && !run_ok) |=> (state_reg == S_OUT && res_status_reg == sec_pkg::ST_OFF))
        else $error("disabled sample did not go straight to output");

    a_off_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_OUT && res_status_reg == sec_pkg::ST_OFF) |-> (res_add_reg == 16'sd0))
        else $error("nonzero addition with controller off");

endmodule

[bench/tb_slip_envelope_steer_controller_unit.sv]
`timescale 1ns / 100ps

module tb_slip_envelope_steer_controller_unit;

    localparam int FRONT_MM = 1350;
    localparam int REAR_MM = 1450;
    localparam int MASS = 1700;
    localparam int FLOOR = 256;
    localparam int STALL_LIMIT = 20000;
    localparam int DRAIN_CYCLES = 400;

    typedef struct {
        logic [15:0]        mu;
        logic signed [15:0] front_slip;
        logic signed [15:0] drv_steer;
        logic signed [15:0] yaw;
        logic [15:0]        spd;
        logic               shore;
        logic signed [15:0] meas;
        logic               en;
    } sample_t;

    typedef struct {
        logic signed [15:0] addition;
        logic [1:0]         stat;
    } steer_out_t;

    class steer_scoreboard;
        longint regs[8];
        longint kept_steer;
        longint kept_yaw;
        steer_out_t pending[$];
        int fails;

        function new();
            regs = '{100000, 150000, 16384, 16384, 32768, 32768, 4096, 4096};
            kept_steer = 0;
            kept_yaw = 0;
            fails = 0;
        endfunction

        function void write_reg(int idx, longint val);
            regs[idx] = val & ((idx < 2) ? 64'hFFFFF : 64'hFFFF);
        endfunction

        function longint abs64(longint v);
            return v < 0 ? -v : v;
        endfunction

        function longint axle_angle(longint num, longint den);
            longint x, y, z, dx, dy;
            x = den;
            y = num;
            z = 0;
            if (num == 0 && den == 0)
                return 0;
            for (int i = 0; i < sec_pkg::ITER; i++)
            begin
                dx = y >>> i;
                dy = x >>> i;
                if (y > 0)
                begin
                    x += dx; y -= dy; z += sec_pkg::atan_entry(sec_pkg::ITER_W'(i));
                end
                else
                begin
                    x -= dx; y += dy; z -= sec_pkg::atan_entry(sec_pkg::ITER_W'(i));
                end
            end
            if (z < 0) z = 0;
            if (z > sec_pkg::HALF_PI_Q16) z = sec_pkg::HALF_PI_Q16;
            return z;
        endfunction

        function longint tangent(longint th);
            longint x, y, z, z0, dx, dy, q;
            z = th * 16;
            x = 64'sd1 << 30;
            y = 0;
            while (z > sec_pkg::HALF_PI_Q16) z -= sec_pkg::PI_Q16;
            while (z < -sec_pkg::HALF_PI_Q16) z += sec_pkg::PI_Q16;
            z0 = z;
            for (int i = 0; i < sec_pkg::ITER; i++)
            begin
                dx = y >>> i;
                dy = x >>> i;
                if (z >= 0)
                begin
                    x -= dx; y += dy; z -= sec_pkg::atan_entry(sec_pkg::ITER_W'(i));
                end
                else
                begin
                    x += dx; y -= dy; z += sec_pkg::atan_entry(sec_pkg::ITER_W'(i));
                end
            end
            if (x <= 0)
                return z0 >= 0 ? 32767 : -32767;
            q = (y * 4096) / x;
            if (q > 32767) q = 32767;
            if (q < -32767) q = -32767;
            return q;
        endfunction

        function longint slip_limit(longint stiff, longint scale, bit shore,
                                    longint safety, longint mu, longint load);
            longint c, ang;
            c = shore ? ((stiff * scale) >> 14) : stiff;
            ang = axle_angle(3 * mu * load, c * 1638400);
            return (safety * ang + (64'sd1 << 18)) >>> 19;
        endfunction

        function longint yaw_over_speed(longint k_mm, longint r, longint v);
            return (k_mm * r * 256) / (1000 * v);
        endfunction

        function longint peak_slip(longint a, longint t);
            longint s, d;
            s = a > 0 ? 1 : (a < 0 ? -1 : 0);
            d = 12288 - abs64(a) + t;
            if (d == 0) d = 1;
            return (s * 3 * t * 4096) / d;
        endfunction

        function void note_sample(sample_t s);
            longint weight, load_f, load_r, v, th, beta, ar, afhw, tf, tr, add;
            steer_out_t e;
            weight = longint'(MASS) * 981;
            load_f = (weight * REAR_MM) / (FRONT_MM + REAR_MM);
            load_r = weight - load_f;
            v = s.spd;
            add = 0;
            e.stat = sec_pkg::ST_OFF;
            if (s.en && v > FLOOR)
            begin
                th = longint'(s.front_slip) + kept_steer;
                beta = tangent(th) - yaw_over_speed(FRONT_MM, kept_yaw, v);
                ar = th - yaw_over_speed(FRONT_MM + REAR_MM, kept_yaw, v);
                afhw = beta + yaw_over_speed(FRONT_MM, s.yaw, v) - s.drv_steer;
                tf = slip_limit(regs[sec_pkg::REG_FRONT_STIFF], regs[sec_pkg::REG_FRONT_SHORE],
                                s.shore, regs[sec_pkg::REG_FRONT_SAFE], s.mu, load_f);
                tr = slip_limit(regs[sec_pkg::REG_REAR_STIFF], regs[sec_pkg::REG_REAR_SHORE],
                                s.shore, regs[sec_pkg::REG_REAR_SAFE], s.mu, load_r);
                if (abs64(ar) > tr)
                begin
                    e.stat = sec_pkg::ST_REAR;
                    add = ((regs[sec_pkg::REG_REAR_GAIN] * (ar - peak_slip(ar, tr))) >>> 12)
                        - s.drv_steer;
                end
                else if (abs64(afhw) < tf)
                begin
                    e.stat = sec_pkg::ST_NONE;
                end
                else
                begin
                    e.stat = sec_pkg::ST_FRONT;
                    add = kept_steer
                        + ((regs[sec_pkg::REG_FRONT_GAIN]
                            * (s.front_slip - peak_slip(afhw, tf))) >>> 12) - s.drv_steer;
                end
                if (add > 32767) add = 32767;
                if (add < -32768) add = -32768;
            end
            e.addition = add[15:0];
            kept_steer = s.meas;
            kept_yaw = s.yaw;
            pending.push_back(e);
        endfunction

        function void check_result(logic signed [15:0] addition, logic [1:0] stat);
            steer_out_t e;
            if (pending.size() == 0)
            begin
                $error("result with nothing pending: steer_addition %0d status %0d",
                       addition, stat);
                fails++;
                return;
            end
            e = pending.pop_front();
            if (addition !== e.addition)
            begin
                $error("steer_addition expected %0d actual %0d", e.addition, addition);
                fails++;
            end
            if (stat !== e.stat)
            begin
                $error("status expected %0d actual %0d", e.stat, stat);
                fails++;
            end
        endfunction
    endclass

    logic clk = 0;
    logic rst_n = 0;
    logic psel = 0, penable = 0, pwrite = 0;
    logic [4:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;
    logic in_valid = 0, in_ready;
    logic [15:0] friction_est = '0;
    logic signed [15:0] front_slip_est = '0, driver_steer = '0, yaw_rate = '0;
    logic [15:0] speed = '0;
    logic at_shoreline = 0;
    logic signed [15:0] measured_steer = '0;
    logic enable = 0;
    logic out_valid, out_ready = 0;
    logic signed [15:0] steer_addition;
    logic [1:0] status;

    steer_scoreboard sb = new();
    bit busy_sides = 1;
    int quiet_cycles = 0;

    slip_envelope_steer_controller_unit #(
        .FRONT_AXLE_MM(FRONT_MM),
        .REAR_AXLE_MM(REAR_MM),
        .MASS_KG(MASS),
        .SPEED_FLOOR(FLOOR)
    ) dut (.*);

    always
    begin
        #10 clk = 1;
        #10 clk = 0;
    end

    always @(posedge clk)
    begin
        sample_t s;
        if (in_valid && in_ready)
        begin
            s.mu = friction_est; s.front_slip = front_slip_est;
            s.drv_steer = driver_steer; s.yaw = yaw_rate; s.spd = speed;
            s.shore = at_shoreline; s.meas = measured_steer; s.en = enable;
            sb.note_sample(s);
        end
        if (out_valid && out_ready)
            sb.check_result(steer_addition, status);
        if ((in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    always @(negedge clk)
        out_ready <= busy_sides ? ($urandom_range(99) >= 35) : 1'b1;

    task automatic write_reg(int idx, logic [31:0] val);
        @(negedge clk);
        psel <= 1; penable <= 0; pwrite <= 1; paddr <= 5'(4 * idx); pwdata <= val;
        @(negedge clk);
        penable <= 1;
        @(negedge clk);
        psel <= 0; penable <= 0; pwrite <= 0;
        sb.write_reg(idx, val);
    endtask

    task automatic send_sample(sample_t s);
        while (busy_sides && $urandom_range(99) < 35)
        begin
            in_valid <= 0;
            @(negedge clk);
        end
        friction_est <= s.mu; front_slip_est <= s.front_slip;
        driver_steer <= s.drv_steer; yaw_rate <= s.yaw; speed <= s.spd;
        at_shoreline <= s.shore; measured_steer <= s.meas; enable <= s.en;
        in_valid <= 1;
        do
            @(posedge clk);
        while (!in_ready);
        @(negedge clk);
    endtask

    task automatic drain();
        in_valid <= 0;
        while (sb.pending.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    function automatic logic signed [15:0] small_angle();
        case ($urandom_range(3))
            0: return 16'($urandom);
            1: return 16'(int'($urandom_range(8000)) - 4000);
            default: return 16'(int'($urandom_range(1600)) - 800);
        endcase
    endfunction

    function automatic sample_t random_sample();
        sample_t s;
        s.mu = ($urandom_range(4) == 0) ? 16'($urandom) : 16'($urandom_range(20000));
        s.front_slip = small_angle();
        s.drv_steer = small_angle();
        s.yaw = small_angle();
        case ($urandom_range(5))
            0: s.spd = 16'($urandom);
            1: s.spd = 16'($urandom_range(FLOOR + 2));
            default: s.spd = 16'($urandom_range(12000, FLOOR + 1));
        endcase
        s.shore = 1'($urandom_range(1));
        s.meas = small_angle();
        s.en = $urandom_range(9) != 0;
        return s;
    endfunction

    function automatic sample_t make_sample(logic [15:0] mu, int af, int dhw, int r,
                                            logic [15:0] v, bit shore, int meas, bit en);
        sample_t s;
        s.mu = mu; s.front_slip = 16'(af); s.drv_steer = 16'(dhw); s.yaw = 16'(r);
        s.spd = v; s.shore = shore; s.meas = 16'(meas); s.en = en;
        return s;
    endfunction

    initial
    begin
        sample_t directed[$];
        logic [31:0] cfg;
        repeat (4) @(negedge clk);
        rst_n <= 1;
        @(negedge clk);

        directed.push_back(make_sample(16384, 100, 0, 0, 5000, 0, 0, 0));
        directed.push_back(make_sample(16384, 100, 0, 0, FLOOR, 0, 0, 1));
        directed.push_back(make_sample(16384, 100, 0, 0, FLOOR + 1, 0, 0, 1));
        directed.push_back(make_sample(0, 0, 0, 0, 5000, 0, 0, 1));
        directed.push_back(make_sample(65535, 32767, 32767, 32767, 65535, 1, 32767, 1));
        directed.push_back(make_sample(65535, -32768, -32768, -32768, 65535, 0, -32768, 1));
        directed.push_back(make_sample(16384, 32767, -32768, 32767, 300, 0, 32767, 1));
        directed.push_back(make_sample(16384, 6434, 0, -32768, 300, 1, -6434, 1));
        directed.push_back(make_sample(16384, -6434, 0, 0, 2560, 0, 0, 1));
        directed.push_back(make_sample(16384, 3000, 500, 200, 2560, 0, 1000, 1));
        directed.push_back(make_sample(16384, -3000, -500, -200, 2560, 1, -1000, 1));
        directed.push_back(make_sample(4000, 12288, 0, 0, 2560, 0, 0, 1));
        directed.push_back(make_sample(1000, 400, 200, 100, 7680, 0, 0, 1));
        directed.push_back(make_sample(0, -32768, 0, 0, 65535, 1, 0, 1));
        directed.push_back(make_sample(16384, 0, 32767, 0, 0, 0, 0, 1));
        foreach (directed[i])
            send_sample(directed[i]);
        drain();

        for (int phase = 0; phase < 5; phase++)
        begin
            for (int idx = 0; idx < 8; idx++)
            begin
                case (phase)
                    0: cfg = 0;
                    1: cfg = (idx < 2) ? 32'hFFFFF : 32'hFFFF;
                    2: cfg = (idx == sec_pkg::REG_FRONT_SAFE || idx == sec_pkg::REG_REAR_SAFE)
                             ? 32768 : 0;
                    default: cfg = $urandom;
                endcase
                if (phase >= 3
                    && (idx == sec_pkg::REG_FRONT_SAFE || idx == sec_pkg::REG_REAR_SAFE))
                    cfg = $urandom_range(32768);
                write_reg(idx, cfg);
            end
            busy_sides = (phase != 2);
            repeat (380)
                send_sample(random_sample());
            drain();
        end

        if (sb.fails == 0 && sb.pending.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule
